[rtl/oai_pkg.sv]
// ----------------------------------------------------------------------------
// oai_pkg
// Shared types and codes for the ordered array insert/remove unit.
// ----------------------------------------------------------------------------
`default_nettype none

package oai_pkg;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int IDX_W    = 6;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [POS_W-1:0]          pos_t;
    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [OP_W-1:0]           opcode_t;
    typedef logic [STATUS_W-1:0]       status_t;

    localparam opcode_t OP_INSERT = 2'd0;
    localparam opcode_t OP_REMOVE = 2'd1;
    localparam opcode_t OP_APPEND = 2'd2;

    localparam status_t STAT_DONE   = 2'd0;
    localparam status_t STAT_FULL   = 2'd1;
    localparam status_t STAT_BADPOS = 2'd2;

    // one write port and one read port, addresses at full index width
    typedef struct packed {
        logic   we;
        idx_t   waddr;
        value_t wdata;
        logic   re;
        idx_t   raddr;
    } mem_req_t;

endpackage

`default_nettype wire

[rtl/oai_ifs.sv]
// ----------------------------------------------------------------------------
// oai_ifs
// Request and result channels of the ordered array insert/remove unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface oai_req_if;
    logic            valid;
    logic            ready;
    oai_pkg::opcode_t opcode;
    oai_pkg::value_t  item_value;
    oai_pkg::pos_t    position;

    modport source (output valid, output opcode, output item_value, output position,
                    input ready);
    modport sink   (input valid, input opcode, input item_value, input position,
                    output ready);
endinterface

interface oai_rsp_if;
    logic             valid;
    logic             ready;
    oai_pkg::value_t  element;
    oai_pkg::idx_t    element_index;
    logic             has_element;
    oai_pkg::status_t status;
    logic             last;

    modport source (output valid, output element, output element_index,
                    output has_element, output status, output last, input ready);
    modport sink   (input valid, input element, input element_index,
                    input has_element, input status, input last, output ready);
endinterface

`default_nettype wire

[rtl/oai_mem.sv]
// ----------------------------------------------------------------------------
// oai_mem
// Array storage: one write port, one read port, registered read data that
// holds its value while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module oai_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic              clk,
    input  wire oai_pkg::mem_req_t mreq,
    output oai_pkg::value_t        rdata
);

    oai_pkg::value_t mem [DEPTH];
    oai_pkg::value_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mreq.we)
        begin
            mem[mreq.waddr[AW-1:0]] <= mreq.wdata;
        end
        if (mreq.re)
        begin
            rdata_reg <= mem[mreq.raddr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/ordered_array_insert_remove_unit.sv]
// ----------------------------------------------------------------------------
// ordered_array_insert_remove_unit
// Ordered array of signed words with insert, remove and append; streams the
// whole array after every request.
// ----------------------------------------------------------------------------
// Usage:
//   req : one transfer per request (opcode, item_value, position). Ready is
//         high only while the unit is idle; one request is handled at a time.
//   rsp : after the array is updated, one transfer per stored word in index
//         order, last set on the final one. An empty array gives a single
//         transfer with has_element low. Rejected requests still stream the
//         unchanged array with the reason in status.
//   Order: entries are moved one word at a time through the array memory's
//   one read port and one write port (read k, write its neighbour the next
//   cycle), then the commit step, then one result per cycle while rsp is ready.
//   Results pass through an output register, so the next request is taken
//   while the final result of the previous one still waits.
//   A stalled receiver holds the output register and the stream simply waits.
//   Reset empties the array (count to zero); no memory clearing pass is
//   needed since only entries below count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_array_insert_remove_unit #(
    parameter int DEPTH = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    oai_req_if.sink   req,
    oai_rsp_if.source rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SHIFT  = 4'b0010,
        ST_COMMIT = 4'b0100,
        ST_STREAM = 4'b1000
    } state_t;

    state_t            state_reg,    state_next;
    logic [CW-1:0]     count_reg,    count_next;
    oai_pkg::status_t  status_reg,   status_next;
    logic              ins_reg,      ins_next;
    oai_pkg::value_t   val_reg,      val_next;
    logic [AW-1:0]     put_idx_reg,  put_idx_next;
    logic [AW-1:0]     rd_ptr_reg,   rd_ptr_next;
    logic [AW-1:0]     end_ptr_reg,  end_ptr_next;
    logic              wr_pend_reg,  wr_pend_next;
    logic [AW-1:0]     wr_addr_reg,  wr_addr_next;
    logic [CW-1:0]     str_idx_reg,  str_idx_next;
    logic              pend_reg,     pend_next;
    oai_pkg::idx_t     pend_idx_reg, pend_idx_next;
    logic              pend_last_reg, pend_last_next;

    logic              out_valid_reg, out_valid_next;
    oai_pkg::value_t   out_elem_reg,  out_elem_next;
    oai_pkg::idx_t     out_idx_reg,   out_idx_next;
    logic              out_has_reg,   out_has_next;
    oai_pkg::status_t  out_stat_reg,  out_stat_next;
    logic              out_last_reg,  out_last_next;

    oai_pkg::mem_req_t mreq;
    oai_pkg::value_t   rdata;

    oai_pkg::pos_t     cnt_ext;
    oai_pkg::pos_t     ins_idx;
    logic              out_free;
    logic              move;
    logic              issue;

    oai_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .mreq  (mreq),
        .rdata (rdata)
    );

    assign cnt_ext  = oai_pkg::pos_t'(count_reg);
    assign out_free = !out_valid_reg || rsp.ready;
    assign move     = (state_reg == ST_STREAM) && pend_reg && out_free;
    assign issue    = (state_reg == ST_STREAM) && (str_idx_reg < count_reg)
                      && (!pend_reg || move);
    assign ins_idx  = ((req.opcode == oai_pkg::OP_APPEND) || (req.position > cnt_ext))
                      ? cnt_ext : req.position;

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        ins_next       = ins_reg;
        val_next       = val_reg;
        put_idx_next   = put_idx_reg;
        rd_ptr_next    = rd_ptr_reg;
        end_ptr_next   = end_ptr_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = wr_addr_reg;
        str_idx_next   = str_idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        pend_last_next = pend_last_reg;

        out_valid_next = out_valid_reg && !rsp.ready;
        out_elem_next  = out_elem_reg;
        out_idx_next   = out_idx_reg;
        out_has_next   = out_has_reg;
        out_stat_next  = out_stat_reg;
        out_last_next  = out_last_reg;

        // a pending shift write always lands the cycle after its read
        mreq.we    = wr_pend_reg;
        mreq.waddr = oai_pkg::idx_t'(wr_addr_reg);
        mreq.wdata = rdata;
        mreq.re    = 1'b0;
        mreq.raddr = oai_pkg::idx_t'(rd_ptr_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    status_next  = oai_pkg::STAT_DONE;
                    str_idx_next = '0;
                    val_next     = req.item_value;
                    state_next   = ST_STREAM;
                    unique case (req.opcode) inside
                        oai_pkg::OP_INSERT, oai_pkg::OP_APPEND:
                        begin
                            ins_next = 1'b1;
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = oai_pkg::STAT_FULL;
                            end
                            else
                            begin
                                put_idx_next = ins_idx[AW-1:0];
                                end_ptr_next = ins_idx[AW-1:0];
                                rd_ptr_next  = AW'(count_reg - CW'(1));
                                state_next   = (ins_idx < cnt_ext) ? ST_SHIFT : ST_COMMIT;
                            end
                        end
                        oai_pkg::OP_REMOVE:
                        begin
                            ins_next = 1'b0;
                            if ((req.position == '0) || (req.position > cnt_ext))
                            begin
                                status_next = oai_pkg::STAT_BADPOS;
                            end
                            else
                            begin
                                rd_ptr_next  = req.position[AW-1:0];
                                end_ptr_next = AW'(count_reg - CW'(1));
                                state_next   = (req.position < cnt_ext) ? ST_SHIFT
                                                                        : ST_COMMIT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_STREAM;
                        end
                    endcase
                end
            end

            ST_SHIFT:
            begin
                mreq.re      = 1'b1;
                wr_pend_next = 1'b1;
                wr_addr_next = ins_reg ? rd_ptr_reg + AW'(1) : rd_ptr_reg - AW'(1);
                if (rd_ptr_reg == end_ptr_reg)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    rd_ptr_next = ins_reg ? rd_ptr_reg - AW'(1) : rd_ptr_reg + AW'(1);
                end
            end

            ST_COMMIT:
            begin
                // drain the last shift write first; the port is free after that
                if (!wr_pend_reg)
                begin
                    if (ins_reg)
                    begin
                        mreq.we    = 1'b1;
                        mreq.waddr = oai_pkg::idx_t'(put_idx_reg);
                        mreq.wdata = val_reg;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    state_next = ST_STREAM;
                end
            end

            ST_STREAM:
            begin
                mreq.raddr = oai_pkg::idx_t'(str_idx_reg);
                mreq.re    = issue;
                if (count_reg == '0)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_elem_next  = '0;
                        out_idx_next   = '0;
                        out_has_next   = 1'b0;
                        out_stat_next  = status_reg;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    if (move)
                    begin
                        out_valid_next = 1'b1;
                        out_elem_next  = rdata;
                        out_idx_next   = pend_idx_reg;
                        out_has_next   = 1'b1;
                        out_stat_next  = status_reg;
                        out_last_next  = pend_last_reg;
                        if (pend_last_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    pend_next = issue || (pend_reg && !move);
                    if (issue)
                    begin
                        pend_idx_next  = oai_pkg::idx_t'(str_idx_reg);
                        pend_last_next = (str_idx_reg == count_reg - CW'(1));
                        str_idx_next   = str_idx_reg + CW'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            wr_pend_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wr_pend_reg   <= wr_pend_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        ins_reg       <= ins_next;
        val_reg       <= val_next;
        put_idx_reg   <= put_idx_next;
        rd_ptr_reg    <= rd_ptr_next;
        end_ptr_reg   <= end_ptr_next;
        wr_addr_reg   <= wr_addr_next;
        str_idx_reg   <= str_idx_next;
        pend_idx_reg  <= pend_idx_next;
        pend_last_reg <= pend_last_next;
        out_elem_reg  <= out_elem_next;
        out_idx_reg   <= out_idx_next;
        out_has_reg   <= out_has_next;
        out_stat_reg  <= out_stat_next;
        out_last_reg  <= out_last_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.element       = out_elem_reg;
    assign rsp.element_index = out_idx_reg;
    assign rsp.has_element   = out_has_reg;
    assign rsp.status        = out_stat_reg;
    assign rsp.last          = out_last_reg;

    // no shift write or read-ahead may be left over once a request is finished
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!wr_pend_reg && !pend_reg))
        else $error("leftover memory access in idle");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count beyond depth");

    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != ST_IDLE))
        else $error("request transfer left unit idle");

    // the read data register must not be overwritten before it is moved out
    a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STREAM && pend_reg && !out_free) |-> !mreq.re)
        else $error("stream read overwrote pending word");

endmodule

`default_nettype wire
